>>> rtl/core/rrv_pkg.sv
package rrv_pkg;

    // Width of one stored return and of the volatility result.
    localparam int RET_W = 24;
    localparam int VOL_W = 24;

    // Saturation limits of a return.
    localparam logic [31:0] RET_POS_MAX = 32'd8388607;
    localparam logic [31:0] RET_NEG_MAG = 32'd8388608;

    // Configuration register indexes.
    localparam logic [7:0] CFG_WINDOW_LENGTH = 8'd0;
    localparam logic [7:0] CFG_VOL_THRESHOLD = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [8:0]  WINDOW_RESET    = 9'd20;
    localparam logic [23:0] THRESHOLD_RESET = 24'd20972;

    typedef logic signed [RET_W-1:0] t_ret;

    // Command to the shared divide and square root unit.
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_iter_ctrl;

endpackage

>>> rtl/core/rolling_return_volatility_regime_top.sv
// Rolling volatility of bar returns: each transaction carries one close and yields one
// result with the population standard deviation of the last window_length returns in
// Q3.20, a regime bit and a flat signal. Returns are held in a ring memory with a running
// sum and sum of squares. One transaction is processed at a time, using the shared
// bit-serial unit (IW = 56 bits wide by default) that performs the return division,
// the mean and mean-square divisions and the square root in turn. A new close is
// taken as soon as the previous result is latched.
module rolling_return_volatility_regime_top #(
    parameter int WINDOW_MAX = 256,
    parameter int FRAC_BITS  = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_close_price,
    input  logic [63:0] i_bar_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_bar_index,
    output logic [63:0] o_bar_time_out,
    output logic [23:0] o_volatility,
    output logic        o_high_regime,
    output logic        o_stay_flat,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int LOG_W  = $clog2(WINDOW_MAX);
    localparam int SUM_W  = rrv_pkg::RET_W + LOG_W;
    localparam int SQ_W   = 2 * rrv_pkg::RET_W - 1 + LOG_W;
    localparam int RAW_W  = (32 + FRAC_BITS > SQ_W) ? 32 + FRAC_BITS : SQ_W;
    localparam int IW     = RAW_W + (RAW_W % 2);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RET   = 11'b00000000010,
        S_OLD   = 11'b00000000100,
        S_NEW   = 11'b00000001000,
        S_ADD   = 11'b00000010000,
        S_MEAN  = 11'b00000100000,
        S_MWAIT = 11'b00001000000,
        S_MSQ   = 11'b00010000000,
        S_QWAIT = 11'b00100000000,
        S_SQRT  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state              r_state;
    logic [8:0]          r_window;
    logic [23:0]         r_thresh;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]     r_sq;
    logic [31:0]         r_last;
    logic                r_seen;
    logic [31:0]         r_counter;
    logic [31:0]         r_idx;
    logic [63:0]         r_time;
    logic                r_evict;
    logic                r_neg;
    rrv_pkg::t_ret       r_ret;
    logic [47:0]         r_prod;
    logic [23:0]         r_mean;
    logic [23:0]         r_vol;
    logic                r_out_valid;
    logic [31:0]         r_out_idx;
    logic [63:0]         r_out_time;
    logic [23:0]         r_out_vol;
    logic                r_out_high;

    logic                w_accept;
    logic [31:0]         w_w;
    logic                w_evict;
    logic [31:0]         w_old32;
    logic [IDX_W-1:0]    w_old_idx;
    logic                w_neg;
    logic [31:0]         w_diff;
    rrv_pkg::t_iter_ctrl w_ctrl;
    logic [IW-1:0]       w_num;
    logic [31:0]         w_den;
    logic                w_done;
    logic [IW-1:0]       w_res;
    rrv_pkg::t_ret       w_old;
    logic [23:0]         w_old_mag;
    logic [23:0]         w_ret_mag;
    logic [SUM_W-1:0]    w_sum_mag;
    rrv_pkg::t_ret       w_sat;
    logic [SQ_W-1:0]     w_q;
    logic [63:0]         w_var;
    logic                w_wr_en;
    logic                w_out_load;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Effective window length, clamped to one and to the ring depth.
    always_comb begin
        w_w = 32'(r_window);
        if (w_w == 32'd0) begin
            w_w = 32'd1;
        end else if (w_w > 32'(WINDOW_MAX)) begin
            w_w = 32'(WINDOW_MAX);
        end
        w_evict = 32'(r_count) >= w_w;
        if (32'(r_head) >= 32'(r_count)) begin
            w_old32 = 32'(r_head) - 32'(r_count);
        end else begin
            w_old32 = 32'(r_head) + 32'(WINDOW_MAX) - 32'(r_count);
        end
        w_old_idx = w_old32[IDX_W-1:0];
        w_neg     = i_close_price < r_last;
        w_diff    = w_neg ? r_last - i_close_price : i_close_price - r_last;
    end

    // Magnitudes and saturation of the return.
    always_comb begin
        w_old_mag = w_old[23] ? 24'(-w_old) : 24'(w_old);
        w_ret_mag = r_ret[23] ? 24'(-r_ret) : 24'(r_ret);
        w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        if (r_neg) begin
            if (w_res >= IW'(rrv_pkg::RET_NEG_MAG)) begin
                w_sat = rrv_pkg::t_ret'(24'h800000);
            end else begin
                w_sat = rrv_pkg::t_ret'(-w_res[23:0]);
            end
        end else begin
            if (w_res > IW'(rrv_pkg::RET_POS_MAX)) begin
                w_sat = rrv_pkg::t_ret'(rrv_pkg::RET_POS_MAX[23:0]);
            end else begin
                w_sat = rrv_pkg::t_ret'(w_res[23:0]);
            end
        end
        w_q   = w_res[SQ_W-1:0];
        w_var = 64'(w_q) - 64'(r_prod);
    end

    // Commands to the shared iterative unit.
    always_comb begin
        w_ctrl = '0;
        w_num  = '0;
        w_den  = 32'(r_count);
        unique case (1'b1)
            (r_state == S_IDLE): begin
                w_ctrl.start = w_accept && r_seen && (r_last != 32'd0);
                w_num        = IW'({w_diff, FRAC_BITS'(0)});
                w_den        = r_last;
            end
            (r_state == S_MEAN): begin
                w_ctrl.start = (r_count != '0);
                w_num        = IW'(w_sum_mag);
            end
            (r_state == S_MSQ): begin
                w_ctrl.start = 1'b1;
                w_num        = IW'(r_sq);
            end
            (r_state == S_QWAIT): begin
                w_ctrl.start     = w_done && (64'(w_q) > 64'(r_prod));
                w_ctrl.sqrt_mode = 1'b1;
                w_num            = IW'(w_var);
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    assign w_wr_en = (r_state == S_NEW);

    rrv_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (r_ret),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_old_idx),
        .o_rd_data (w_old)
    );

    rrv_iter #(
        .N (IW),
        .D (32)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_num    (w_num),
        .i_den    (w_den),
        .o_done   (w_done),
        .o_result (w_res)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= rrv_pkg::WINDOW_RESET;
            r_thresh <= rrv_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == rrv_pkg::CFG_WINDOW_LENGTH) begin
                r_window <= i_cfg_data[8:0];
            end else if (i_cfg_index == rrv_pkg::CFG_VOL_THRESHOLD) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    // Sequencer and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx     <= r_counter;
                        r_time    <= i_bar_time;
                        r_counter <= r_counter + 32'd1;
                        r_seen    <= 1'b1;
                        r_last    <= i_close_price;
                        r_evict   <= w_evict;
                        r_neg     <= w_neg;
                        r_ret     <= '0;
                        if (!r_seen) begin
                            r_state <= S_MEAN;
                        end else if (r_last == 32'd0) begin
                            r_state <= S_OLD;
                        end else begin
                            r_state <= S_RET;
                        end
                    end
                end
                S_RET: begin
                    if (w_done) begin
                        r_ret   <= w_sat;
                        r_state <= S_OLD;
                    end
                end
                S_OLD: begin
                    r_prod  <= r_evict ? w_old_mag * w_old_mag : 48'd0;
                    r_state <= S_NEW;
                end
                S_NEW: begin
                    r_sq   <= r_sq - SQ_W'(r_prod);
                    r_prod <= w_ret_mag * w_ret_mag;
                    if (r_evict) begin
                        r_sum <= r_sum - SUM_W'(w_old) + SUM_W'(r_ret);
                    end else begin
                        r_sum   <= r_sum + SUM_W'(r_ret);
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_head  <= (32'(r_head) == 32'(WINDOW_MAX - 1)) ?
                               '0 : r_head + IDX_W'(1);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sq    <= r_sq + SQ_W'(r_prod);
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (r_count == '0) begin
                        r_vol   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    if (w_done) begin
                        r_mean  <= w_res[23:0];
                        r_state <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    r_prod  <= r_mean * r_mean;
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (w_done) begin
                        if (64'(w_q) > 64'(r_prod)) begin
                            r_state <= S_SQRT;
                        end else begin
                            r_vol   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SQRT: begin
                    if (w_done) begin
                        r_vol   <= w_res[23:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_idx  <= r_idx;
            r_out_time <= r_time;
            r_out_vol  <= r_vol;
            r_out_high <= r_vol > r_thresh;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bar_index    = r_out_idx;
    assign o_bar_time_out = r_out_time;
    assign o_volatility   = r_out_vol;
    assign o_high_regime  = r_out_high;
    assign o_stay_flat    = r_out_high;

    // The fill level never exceeds the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(WINDOW_MAX))
        else $error("window fill level beyond ring depth");

    // The write pointer stays inside the ring.
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < 32'(WINDOW_MAX))
        else $error("ring head out of range");

    // A new result is only presented from the output state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result presented outside the output state");

    // The iterative unit only completes while the sequencer waits for it.
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_RET || r_state == S_MWAIT ||
                    r_state == S_QWAIT || r_state == S_SQRT))
        else $error("iterative unit finished unexpectedly");

endmodule

>>> rtl/core/rrv_ring.sv
module rrv_ring #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  rrv_pkg::t_ret     i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output rrv_pkg::t_ret     o_rd_data
);

    rrv_pkg::t_ret r_mem [DEPTH];
    rrv_pkg::t_ret r_rd_data;

    // Single write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/rrv_iter.sv
module rrv_iter #(
    parameter int N = 56,
    parameter int D = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrv_pkg::t_iter_ctrl i_ctrl,
    input  logic [N-1:0]        i_num,
    input  logic [D-1:0]        i_den,
    output logic                o_done,
    output logic [N-1:0]        o_result
);

    localparam int H   = N / 2;
    localparam int CNT = $clog2(N + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_mode;
    logic [CNT-1:0] r_cnt;
    logic [N-1:0]  r_q;
    logic [D-1:0]  r_den;
    logic [D-1:0]  r_drem;
    logic [H-1:0]  r_srem;
    logic [H-1:0]  r_root;

    logic [D:0]    w_dshift;
    logic [D:0]    w_dtrial;
    logic [H+1:0]  w_sshift;
    logic [H+1:0]  w_scand;
    logic [H+1:0]  w_strial;

    // One quotient bit or one root bit per cycle.
    always_comb begin
        w_dshift = {r_drem, r_q[N-1]};
        w_dtrial = w_dshift - {1'b0, r_den};
        w_sshift = {r_srem, r_q[N-1:N-2]};
        w_scand  = {r_root, 2'b01};
        w_strial = w_sshift - w_scand;
    end

    // Control: busy flag and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mode <= i_ctrl.sqrt_mode;
            r_cnt  <= i_ctrl.sqrt_mode ? CNT'(H) : CNT'(N);
            r_q    <= i_num;
            r_den  <= i_den;
            r_drem <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT'(1);
            if (r_mode) begin
                r_q <= {r_q[N-3:0], 2'b00};
                if (w_sshift >= w_scand) begin
                    r_srem <= w_strial[H-1:0];
                    r_root <= {r_root[H-2:0], 1'b1};
                end else begin
                    r_srem <= w_sshift[H-1:0];
                    r_root <= {r_root[H-2:0], 1'b0};
                end
            end else begin
                if (!w_dtrial[D]) begin
                    r_drem <= w_dtrial[D-1:0];
                    r_q    <= {r_q[N-2:0], 1'b1};
                end else begin
                    r_drem <= w_dshift[D-1:0];
                    r_q    <= {r_q[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_mode ? N'(r_root) : r_q;

endmodule
